// ===== rtl/local_time_with_us_dst_assert.svh =====
// Assertion macros for the local time block.
`ifndef LOCAL_TIME_WITH_US_DST_ASSERT_SVH
`define LOCAL_TIME_WITH_US_DST_ASSERT_SVH
`ifndef SYNTHESIS
`define LTUD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("ltud check failed");
`define LTUD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("ltud check failed");
`else
`define LTUD_ASSERT(name, prop)
`define LTUD_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== rtl/ltud_pkg.sv =====
// Types and constants for the local time block.
`default_nettype none
package ltud_pkg;
  localparam int LatW = 21;
  localparam int LonW = 22;
  localparam int CfgIdxW = 8;
  localparam int Stages = 7;
  typedef enum logic [CfgIdxW-1:0] {
    REG_LATITUDE  = 8'd0,
    REG_LONGITUDE = 8'd1
  } cfg_reg_t;
  localparam logic [25:0] DayRecip = 26'd50903317;  // 2^35/675, rounded up
  localparam logic [15:0] QuadRecip = 16'd45934;    // 2^26/1461, rounded up
  localparam logic [16:0] WeekRecip = 17'd74899;    // 2^19/7, rounded up
  localparam logic [15:0] Day2100 = 16'd47482;
  localparam logic [15:0] Day2101 = 16'd47847;
endpackage
`default_nettype wire

// ===== rtl/local_time_with_us_dst.sv =====
// UTC to local time with a US daylight saving rule, as a seven stage pipeline.
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// Zone offset is recomputed from the position registers every cycle.
// Reset (rst, synchronous) empties the pipeline and restores the default position.
`default_nettype none
`include "local_time_with_us_dst_assert.svh"
module local_time_with_us_dst (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // unix_time
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // local_time[33:0], zone_offset_seconds[50:34], zeros
  output logic             m_tuser,   // dst_active
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ltud_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [21:0] cfg_data
);
  import ltud_pkg::*;

  logic signed [LatW-1:0] latitude;
  logic signed [LonW-1:0] longitude;
  logic signed [4:0]  zone_h;
  logic signed [16:0] zone_off;

  logic [Stages-1:0] v;
  logic en;

  logic [31:0] t1, t2, t3, t4, t5, t6;
  logic [50:0] p1;
  logic [15:0] day2, day3, day4, day5, day6;
  logic [16:0] sod3, sod4, sod5, sod6;
  logic [15:0] dd3;
  logic        shift3, y2100_3;
  logic [31:0] p2;
  logic [15:0] ystart4;
  logic        leap4;
  logic [15:0] a5, b5;
  logic [33:0] pa5, pb5;
  logic [15:0] s6, e6;
  logic [33:0] local_q;
  logic        dst_q;

  assign cfg_ready = 1'b1;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude <= 21'sd417401;
      longitude <= -22'sd836491;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LATITUDE: latitude <= cfg_data[LatW-1:0];
        REG_LONGITUDE: longitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // zone offset from position
  logic        in_box;
  logic [21:0] lon_mag;
  logic [22:0] lon_rnd;
  logic [3:0]  hcnt;
  logic signed [4:0] zone_h_next;
  always_comb begin
    in_box = latitude >= 21'sd240000 && latitude <= 21'sd500000 &&
             longitude >= -22'sd1250000 && longitude <= -22'sd660000;
    lon_mag = longitude[LonW-1] ? 22'(-longitude) : 22'(longitude);
    lon_rnd = {1'b0, lon_mag} + 23'd75000;
    hcnt = '0;
    for (int k = 1; k <= 12; k++) begin
      if (lon_rnd >= 23'(150000 * k)) hcnt = hcnt + 4'd1;
    end
    if (in_box) begin
      if (longitude >= -22'sd850000) zone_h_next = -5'sd5;
      else if (longitude >= -22'sd1040000) zone_h_next = -5'sd6;
      else if (longitude >= -22'sd1140000) zone_h_next = -5'sd7;
      else zone_h_next = -5'sd8;
    end else begin
      zone_h_next = longitude[LonW-1] ? -$signed({1'b0, hcnt}) : $signed({1'b0, hcnt});
    end
  end

  always_ff @(posedge clk) begin
    zone_h <= zone_h_next;
    zone_off <= 17'($signed(zone_h) * 17'sd3600);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Stages-2:0], s_tvalid};
    end
  end

  // stage datapath
  logic [10:0] r4;
  logic [5:0]  q4;
  logic [15:0] qb4;
  logic [1:0]  yo4;
  logic [15:0] yoff4;
  logic [16:0] a4p, b4p;
  logic [13:0] qa6, qb6;
  logic [16:0] wa6, wb6;
  logic [2:0]  wda6, wdb6;
  logic [15:0] sa6, se6;
  logic        dst7;
  always_comb begin
    q4 = p2[31:26];
    qb4 = 16'({10'd0, q4} * 16'd1461);
    r4 = 11'(dd3 - qb4);
    if (r4 >= 11'd1096) begin
      yo4 = 2'd3; yoff4 = 16'd1096;
    end else if (r4 >= 11'd730) begin
      yo4 = 2'd2; yoff4 = 16'd730;
    end else if (r4 >= 11'd365) begin
      yo4 = 2'd1; yoff4 = 16'd365;
    end else begin
      yo4 = 2'd0; yoff4 = 16'd0;
    end
    a4p = {1'b0, a5} + 17'd4;
    b4p = {1'b0, b5} + 17'd4;
    qa6 = pa5[32:19];
    qb6 = pb5[32:19];
    wa6 = a4p - 17'({3'd0, qa6} * 17'd7);
    wb6 = b4p - 17'({3'd0, qb6} * 17'd7);
    wda6 = wa6[2:0];
    wdb6 = wb6[2:0];
    sa6 = a5 + ((wda6 == 3'd0) ? 16'd0 : 16'(3'd7 - wda6)) + 16'd7;
    se6 = b5 + ((wdb6 == 3'd0) ? 16'd0 : 16'(3'd7 - wdb6));
    dst7 = latitude > 0 &&
           (day6 > s6 || (day6 == s6 && sod6 >= 17'd7200)) &&
           (day6 < e6 || (day6 == e6 && sod6 < 17'd7200));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= s_tdata;
      p1 <= {1'b0, s_tdata[31:7]} * {25'd0, DayRecip};
      t2 <= t1;
      day2 <= p1[50:35];
      t3 <= t2;
      day3 <= day2;
      sod3 <= 17'(t2 - 32'({16'd0, day2} * 32'd86400));
      shift3 <= day2 >= Day2101;
      y2100_3 <= day2 >= Day2100 && day2 < Day2101;
      dd3 <= (day2 >= Day2101) ? day2 + 16'd1 : day2;
      p2 <= ((day2 >= Day2101) ? day2 + 16'd1 : day2) * QuadRecip;
      t4 <= t3;
      day4 <= day3;
      sod4 <= sod3;
      ystart4 <= qb4 + yoff4 - {15'd0, shift3};
      leap4 <= yo4 == 2'd2 && !y2100_3;
      t5 <= t4;
      day5 <= day4;
      sod5 <= sod4;
      a5 <= ystart4 + 16'd59 + {15'd0, leap4};
      b5 <= ystart4 + 16'd304 + {15'd0, leap4};
      pa5 <= ({1'b0, ystart4} + 17'd63 + {16'd0, leap4}) * WeekRecip;
      pb5 <= ({1'b0, ystart4} + 17'd308 + {16'd0, leap4}) * WeekRecip;
      t6 <= t5;
      day6 <= day5;
      sod6 <= sod5;
      s6 <= sa6;
      e6 <= se6;
      dst_q <= dst7;
      local_q <= {2'b00, t6} + {{17{zone_off[16]}}, zone_off} +
                 (dst7 ? 34'd3600 : 34'd0);
    end
  end

  assign m_tdata = {5'd0, zone_off, local_q};
  assign m_tuser = dst_q;

  `LTUD_ASSERT(stall_keeps_output, m_tvalid && !m_tready |=> m_tvalid)
  `LTUD_ASSERT(dst_needs_north, m_tvalid && m_tuser |-> latitude > 0)
  `LTUD_ASSERT(offset_in_range, zone_off <= 17'sd43200 && zone_off >= -17'sd43200)
  `LTUD_ASSERT_ALWAYS(reset_empties, rst |=> v == '0)
endmodule
`default_nettype wire
